/* src/bkd_pkg.sv */
package bkd_pkg;

    // table geometry: 2^(2*S) sets of S ways
    localparam int S        = 4;
    localparam int NWAYS    = S;
    localparam int SET_W    = 2 * S;
    localparam int NSETS    = 1 << SET_W;
    localparam int WAY_W    = $clog2(NWAYS);
    localparam int ADDR_W   = SET_W + WAY_W;
    localparam int FILL_W   = $clog2(NWAYS + 1);
    localparam int KEY_W    = 64;
    localparam int LEN_W    = 7;
    localparam int CNT_W    = 32;

    localparam logic [LEN_W-1:0] KEY_LENGTH_RESET = LEN_W'(KEY_W);
    localparam logic [CNT_W-1:0] CNT_MAX          = '1;

    typedef enum logic [1:0] {
        ACT_LOOKUP        = 2'd0,
        ACT_LOOKUP_INSERT = 2'd1,
        ACT_INSERT        = 2'd2,
        ACT_NONE          = 2'd3
    } action_t;

    typedef struct packed {
        action_t            action;
        logic [KEY_W-1:0]   key;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic [1:0]         hit_way;
        logic               inserted;
        logic [CNT_W-1:0]   hit_total;
        logic [CNT_W-1:0]   miss_total;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_INSERT,
        ST_DONE
    } state_t;

    // requests from the sequencer to the set store
    typedef struct packed {
        logic               key_rd_en;
        logic [ADDR_W-1:0]  key_rd_addr;
        logic               key_wr_en;
        logic [ADDR_W-1:0]  key_wr_addr;
        logic [KEY_W-1:0]   key_wr_data;
        logic               fill_rd_en;
        logic               fill_wr_en;
        logic [SET_W-1:0]   set_addr;
        logic [FILL_W-1:0]  fill_wr_data;
    } mem_req_t;

    // set number: first S key bits then next S key bits, lowest bit most significant,
    // each field cut short by the key length
    function automatic logic [SET_W-1:0] set_index(input logic [KEY_W-1:0] key,
                                                   input logic [LEN_W-1:0] len);
        logic [S-1:0] first;
        logic [S-1:0] second;
        first  = '0;
        second = '0;
        for (int i = 0; i < S; i++) begin
            if (LEN_W'(i) < len) begin
                first = {first[S-2:0], key[i]};
            end
            if (LEN_W'(S + i) < len) begin
                second = {second[S-2:0], key[S + i]};
            end
        end
        return {first, second};
    endfunction

endpackage

/* src/bkd_cmp.sv */
module bkd_cmp (
    input  logic [bkd_pkg::KEY_W-1:0] stored_key,
    input  logic [bkd_pkg::KEY_W-1:0] probe_key,
    input  logic [bkd_pkg::LEN_W-1:0] eff_len,
    output logic                      match
);
    import bkd_pkg::*;

    logic [KEY_W-1:0] len_mask;

    // low eff_len bits significant
    always_comb begin
        if (eff_len >= LEN_W'(KEY_W)) begin
            len_mask = '1;
        end else begin
            len_mask = ({{(KEY_W-1){1'b0}}, 1'b1} << eff_len) - KEY_W'(1);
        end
    end

    assign match = (((stored_key ^ probe_key) & len_mask) == '0);

endmodule

/* src/bkd_store.sv */
module bkd_store (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bkd_pkg::mem_req_t           req,
    output logic [bkd_pkg::KEY_W-1:0]   key_rd_data,
    output logic [bkd_pkg::FILL_W-1:0]  fill
);
    import bkd_pkg::*;

    logic [KEY_W-1:0]  key_mem [NSETS*NWAYS];
    logic [FILL_W-1:0] fill_mem [NSETS];
    logic [NSETS-1:0]  row_valid_reg;
    logic [KEY_W-1:0]  key_q_reg;
    logic [FILL_W-1:0] fill_q_reg;
    logic              row_valid_q_reg;

    // key words, one per way
    always_ff @(posedge aclk) begin
        if (req.key_wr_en) begin
            key_mem[req.key_wr_addr] <= req.key_wr_data;
        end
        if (req.key_rd_en) begin
            key_q_reg <= key_mem[req.key_rd_addr];
        end
    end

    // per-set fill count
    always_ff @(posedge aclk) begin
        if (req.fill_wr_en) begin
            fill_mem[req.set_addr] <= req.fill_wr_data;
        end
        if (req.fill_rd_en) begin
            fill_q_reg <= fill_mem[req.set_addr];
        end
    end

    // a set never written has fill zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg   <= '0;
            row_valid_q_reg <= 1'b0;
        end else begin
            if (req.fill_wr_en) begin
                row_valid_reg[req.set_addr] <= 1'b1;
            end
            if (req.fill_rd_en) begin
                row_valid_q_reg <= row_valid_reg[req.set_addr];
            end
        end
    end

    assign key_rd_data = key_q_reg;
    assign fill        = row_valid_q_reg ? fill_q_reg : '0;

endmodule

/* src/bkd_ctrl.sv */
module bkd_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  bkd_pkg::in_item_t           item,
    input  logic [bkd_pkg::LEN_W-1:0]   eff_len,
    input  logic                        match,
    input  logic [bkd_pkg::KEY_W-1:0]   key_rd_data,
    input  logic [bkd_pkg::FILL_W-1:0]  fill,
    input  logic                        out_free,
    output logic [bkd_pkg::KEY_W-1:0]   probe_key,
    output bkd_pkg::mem_req_t           req,
    output logic                        res_valid,
    output bkd_pkg::out_item_t          res
);
    import bkd_pkg::*;

    state_t             state_reg, state_next;
    action_t            action_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [SET_W-1:0]   set_reg;
    logic [WAY_W-1:0]   way_reg;
    logic               found_reg;
    logic [WAY_W-1:0]   hit_way_reg;
    logic               inserted_reg;
    logic [CNT_W-1:0]   hit_cnt_reg;
    logic [CNT_W-1:0]   miss_cnt_reg;

    logic accept;
    logic way_live;
    logic cmp_hit;
    logic cmp_miss;
    logic is_lookup;

    assign accept    = item_valid && item_ready;
    assign way_live  = {1'b0, way_reg} < fill;
    assign cmp_hit   = way_live && match;
    assign cmp_miss  = !way_live || (!match && way_reg == WAY_W'(NWAYS - 1));
    assign is_lookup = (action_reg == ACT_LOOKUP) || (action_reg == ACT_LOOKUP_INSERT);
    assign probe_key = key_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                if (is_lookup) begin
                    state_next = ST_CMP;
                end else if (action_reg == ACT_INSERT) begin
                    state_next = ST_SHIFT_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_CMP: begin
                priority if (cmp_hit) begin
                    state_next = ST_DONE;
                end else if (cmp_miss) begin
                    state_next = (action_reg == ACT_LOOKUP_INSERT) ? ST_SHIFT_RD : ST_DONE;
                end else begin
                    state_next = ST_CMP;
                end
            end
            ST_SHIFT_RD: begin
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR: begin
                state_next = (way_reg == '0) ? ST_INSERT : ST_SHIFT_RD;
            end
            ST_INSERT: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and memory requests
    always_comb begin
        req            = '0;
        req.set_addr   = set_reg;
        item_ready     = 1'b0;
        res_valid      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                item_ready = 1'b1;
            end
            ST_FILL: begin
                req.fill_rd_en  = 1'b1;
                req.key_rd_en   = 1'b1;
                req.key_rd_addr = {set_reg, WAY_W'(0)};
            end
            ST_CMP: begin
                // prefetch the next older way
                req.key_rd_en   = 1'b1;
                req.key_rd_addr = {set_reg, WAY_W'(way_reg + WAY_W'(1))};
            end
            ST_SHIFT_RD: begin
                req.key_rd_en   = 1'b1;
                req.key_rd_addr = {set_reg, way_reg};
            end
            ST_SHIFT_WR: begin
                req.key_wr_en   = 1'b1;
                req.key_wr_addr = {set_reg, WAY_W'(way_reg + WAY_W'(1))};
                req.key_wr_data = key_rd_data;
            end
            ST_INSERT: begin
                req.key_wr_en    = 1'b1;
                req.key_wr_addr  = {set_reg, WAY_W'(0)};
                req.key_wr_data  = key_reg;
                req.fill_wr_en   = 1'b1;
                req.fill_wr_data = (fill == FILL_W'(NWAYS)) ? fill : FILL_W'(fill + FILL_W'(1));
            end
            ST_DONE: begin
                res_valid = out_free;
            end
            default: begin
                item_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            found_reg    <= 1'b0;
            inserted_reg <= 1'b0;
            hit_way_reg  <= '0;
            way_reg      <= '0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                found_reg    <= 1'b0;
                inserted_reg <= 1'b0;
                hit_way_reg  <= '0;
                way_reg      <= '0;
            end
            if (state_reg == ST_FILL && action_reg == ACT_INSERT) begin
                way_reg <= WAY_W'(NWAYS - 2);
            end
            if (state_reg == ST_CMP) begin
                priority if (cmp_hit) begin
                    found_reg   <= 1'b1;
                    hit_way_reg <= way_reg;
                    if (hit_cnt_reg != CNT_MAX) begin
                        hit_cnt_reg <= hit_cnt_reg + CNT_W'(1);
                    end
                end else if (cmp_miss) begin
                    way_reg <= WAY_W'(NWAYS - 2);
                    if (miss_cnt_reg != CNT_MAX) begin
                        miss_cnt_reg <= miss_cnt_reg + CNT_W'(1);
                    end
                end else begin
                    way_reg <= way_reg + WAY_W'(1);
                end
            end
            if (state_reg == ST_SHIFT_WR && way_reg != '0) begin
                way_reg <= way_reg - WAY_W'(1);
            end
            if (state_reg == ST_INSERT) begin
                inserted_reg <= 1'b1;
            end
        end
    end

    // item payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            action_reg <= item.action;
            key_reg    <= item.key;
            set_reg    <= set_index(item.key, eff_len);
        end
    end

    always_comb begin
        res            = '0;
        res.found      = found_reg;
        res.hit_way    = 2'(hit_way_reg);
        res.inserted   = inserted_reg;
        res.hit_total  = hit_cnt_reg;
        res.miss_total = miss_cnt_reg;
    end

endmodule

/* src/bit_key_dedup_table_fifo.sv */
// set-associative key table with fifo replacement
//
// input channel s_valid/s_ready/s_data carries one item: an action and a 64-bit key.
// the low key_length bits are compared and at most the low 8 pick the set; the set is
// searched newest way first, one way per cycle through a single shared comparator.
// lookup-and-insert on a miss, or a plain insert, moves the set's ways up by one
// (each way read, then written one way up) and writes the key at way 0.
// result channel m_valid/m_ready/m_data gives found, hit_way, inserted and the
// saturating hit and miss totals after the item.
// steps after acceptance: a set read, then for a lookup the way compares, newest
// first, until a hit or a miss; a miss with insert or a plain insert then shifts the
// ways and writes the key; an unused action goes from the set read to the result.
// the block takes one item at a time and is ready again in the same cycle its result
// is registered. the user writes key_length through cfg_we/cfg_wdata only while the
// block is idle; the block itself does not enforce this.
// reset clears the per-set valid bits, both counters and key_length to 64; the
// table is ready the cycle after reset with no clearing pass.
// a held result sits in the output register; the next item is taken meanwhile
// and waits in its last step until the receiver takes the earlier result.
module bit_key_dedup_table_fifo (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  bkd_pkg::in_item_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output bkd_pkg::out_item_t          m_data,
    input  logic                        cfg_we,
    input  logic [bkd_pkg::LEN_W-1:0]   cfg_wdata
);
    import bkd_pkg::*;

    logic [LEN_W-1:0]  key_length_reg;
    logic [LEN_W-1:0]  eff_len;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    logic              out_free;
    logic              match;
    logic [KEY_W-1:0]  probe_key;
    logic [KEY_W-1:0]  key_rd_data;
    logic [FILL_W-1:0] fill;
    mem_req_t          req;
    logic              res_valid;
    out_item_t         res;

    // key length register, values above the key width act as the key width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_length_reg <= KEY_LENGTH_RESET;
        end else if (cfg_we) begin
            key_length_reg <= cfg_wdata;
        end
    end

    assign eff_len = (key_length_reg > LEN_W'(KEY_W)) ? LEN_W'(KEY_W) : key_length_reg;

    // output register frees when empty or being taken
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
        end else begin
            if (res_valid) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= res;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // sequencer: set read, way compares, way shift, insert
    bkd_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (s_valid),
        .item_ready  (s_ready),
        .item        (s_data),
        .eff_len     (eff_len),
        .match       (match),
        .key_rd_data (key_rd_data),
        .fill        (fill),
        .out_free    (out_free),
        .probe_key   (probe_key),
        .req         (req),
        .res_valid   (res_valid),
        .res         (res)
    );

    // shared masked key comparator
    bkd_cmp u_cmp (
        .stored_key (key_rd_data),
        .probe_key  (probe_key),
        .eff_len    (eff_len),
        .match      (match)
    );

    // key words, fill counts and set valid bits
    bkd_store u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req         (req),
        .key_rd_data (key_rd_data),
        .fill        (fill)
    );

    // an item is never both a hit and an insert
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.found && m_data.inserted))
        else $error("result both found and inserted");

    // a nonzero way only comes with a hit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.hit_way != 2'd0) |-> m_data.found)
        else $error("hit_way set without found");

    // totals never move backward
    assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn |=> (m_data.hit_total >= $past(m_data.hit_total)) &&
                    (m_data.miss_total >= $past(m_data.miss_total)))
        else $error("saturating total decreased");

    // one item at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item taken while busy");

endmodule

/* tb/tb_bit_key_dedup_table_fifo.sv */
module tb_bit_key_dedup_table_fifo;
    timeunit 1ns;
    timeprecision 1ps;

    import bkd_pkg::*;

    // the table as the block should hold it, plus the queue of results still owed
    class dedup_scoreboard;
        logic [KEY_W-1:0] key_store [NSETS*NWAYS];
        bit               way_used  [NSETS*NWAYS];
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
        logic [LEN_W-1:0] key_length;
        out_item_t        owed_q [$];
        int               errors;

        function new();
            foreach (way_used[i]) way_used[i] = 1'b0;
            hits       = '0;
            misses     = '0;
            key_length = KEY_LENGTH_RESET;
            errors     = 0;
        endfunction

        function void set_key_length(logic [LEN_W-1:0] value);
            key_length = value;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // two index fields, each read with its lowest key bit as msb
        function int set_of_key(logic [KEY_W-1:0] key, int len);
            int upper;
            int lower;
            int n_upper;
            int n_lower;
            upper   = 0;
            lower   = 0;
            n_upper = (len < S) ? len : S;
            n_lower = (len > S) ? (((len - S) < S) ? (len - S) : S) : 0;
            for (int i = 0; i < n_upper; i++) upper = upper * 2 + key[i];
            for (int i = 0; i < n_lower; i++) lower = lower * 2 + key[S + i];
            return upper * (1 << S) + lower;
        endfunction

        function void note_input(in_item_t item);
            int               len;
            int               base;
            logic [KEY_W-1:0] cmp_mask;
            out_item_t        res;
            len      = (key_length > KEY_W) ? KEY_W : int'(key_length);
            cmp_mask = (len >= KEY_W) ? '1 : ((64'd1 << len) - 64'd1);
            base     = set_of_key(item.key, len) * NWAYS;
            res      = '0;
            if (item.action == ACT_LOOKUP || item.action == ACT_LOOKUP_INSERT) begin
                for (int w = 0; w < NWAYS; w++) begin
                    if (!way_used[base + w]) break;
                    if (((key_store[base + w] ^ item.key) & cmp_mask) == '0) begin
                        res.found   = 1'b1;
                        res.hit_way = 2'(w);
                        break;
                    end
                end
                if (res.found) begin
                    if (hits != CNT_MAX) hits++;
                end else begin
                    if (misses != CNT_MAX) misses++;
                end
            end
            if (item.action == ACT_INSERT ||
                (item.action == ACT_LOOKUP_INSERT && !res.found)) begin
                for (int w = NWAYS - 1; w > 0; w--) begin
                    key_store[base + w] = key_store[base + w - 1];
                    way_used[base + w]  = way_used[base + w - 1];
                end
                key_store[base] = item.key;
                way_used[base]  = 1'b1;
                res.inserted    = 1'b1;
            end
            res.hit_total  = hits;
            res.miss_total = misses;
            owed_q.push_back(res);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
            errors++;
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (owed_q.size() == 0) begin
                report("result with none owed", 64'(got), '0);
                return;
            end
            want = owed_q.pop_front();
            if (got.found !== want.found)
                report("found", 64'(got.found), 64'(want.found));
            if (got.hit_way !== want.hit_way)
                report("hit_way", 64'(got.hit_way), 64'(want.hit_way));
            if (got.inserted !== want.inserted)
                report("inserted", 64'(got.inserted), 64'(want.inserted));
            if (got.hit_total !== want.hit_total)
                report("hit_total", 64'(got.hit_total), 64'(want.hit_total));
            if (got.miss_total !== want.miss_total)
                report("miss_total", 64'(got.miss_total), 64'(want.miss_total));
        endtask
    endclass

    localparam int CYCLE_LIMIT = 300000;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    in_item_t         s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    out_item_t        m_data;
    logic             cfg_we    = 1'b0;
    logic [LEN_W-1:0] cfg_wdata = '0;

    dedup_scoreboard  sb = new();
    logic [LEN_W-1:0] cur_len = KEY_LENGTH_RESET;
    bit               calm = 1'b0;   // set for a stretch with no idling on either side
    int               cycles = 0;

    always #5 aclk = ~aclk;

    bit_key_dedup_table_fifo dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // receiver stalls at random with odds of about 23 in a hundred, never while calm
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 23);
    end

    // values read here are the ones from before the edge, so this sees the handshake
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // one item: random idle gap, then hold valid until the block takes it
    task send_item(input action_t act, input logic [KEY_W-1:0] key);
        in_item_t item;
        item.action = act;
        item.key    = key;
        while (!calm && $urandom_range(99) < 23) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // accepted at this edge; expectation noted before anything else can look
        sb.note_input(item);
    endtask

    // every item owes exactly one result, so an empty queue means the block is idle
    task drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task write_length(input logic [LEN_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_key_length(value);
        cur_len = value;
    endtask

    // mostly keys from a small pool that crowds two sets, so hits and evictions
    // happen; some carry noise above the key length, which must not matter
    task random_phase(input int count);
        logic [KEY_W-1:0] pool [12];
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] noise;
        action_t          act;
        int               done;
        int               roll;
        int               eff;
        done = 0;
        eff  = (cur_len > KEY_W) ? KEY_W : int'(cur_len);
        foreach (pool[i]) begin
            pool[i]      = {$urandom, $urandom};
            pool[i][7:0] = (i % 2) ? 8'hC3 : 8'h1E;
        end
        while (done < count) begin
            if ($urandom_range(99) < 80) begin
                key = pool[$urandom_range(11)];
                if ($urandom_range(3) == 0) begin
                    noise = {$urandom, $urandom};
                    key   = key ^ (noise << eff);
                end
            end else begin
                key = {$urandom, $urandom};
            end
            roll = $urandom_range(99);
            if (roll < 35)      act = ACT_LOOKUP;
            else if (roll < 70) act = ACT_LOOKUP_INSERT;
            else if (roll < 90) act = ACT_INSERT;
            else                act = ACT_NONE;
            send_item(act, key);
            // unused action only echoes the counters, so it is not counted
            if (act != ACT_NONE) done++;
        end
    endtask

    initial begin
        int phase_len [8];

        aresetn <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // full key length after reset
        send_item(ACT_LOOKUP, '0);                    // miss in a set never written
        send_item(ACT_INSERT, '1);
        send_item(ACT_LOOKUP, '1);                    // hit at newest way
        send_item(ACT_LOOKUP_INSERT, '0);             // miss, then insert
        send_item(ACT_LOOKUP_INSERT, '0);             // hit, no insert
        send_item(ACT_NONE, '1);                      // unused action, counters unchanged
        // five keys into one set: the first falls out of the oldest way
        for (int i = 1; i <= 5; i++) send_item(ACT_INSERT, 64'h5A | (64'(i) << 40));
        send_item(ACT_LOOKUP, 64'h5A | (64'd1 << 40)); // evicted
        send_item(ACT_LOOKUP, 64'h5A | (64'd2 << 40)); // oldest way
        send_item(ACT_LOOKUP, 64'h5A | (64'd5 << 40)); // newest way
        send_item(ACT_LOOKUP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);

        // zero length: one set, any valid way matches
        write_length('0);
        send_item(ACT_INSERT, 64'h1234);
        send_item(ACT_LOOKUP, 64'hFFFF_0000_0000_0000);

        // length beyond the key width behaves as full width; stored keys stay whole
        write_length('1);
        send_item(ACT_LOOKUP, 64'h5A | (64'd5 << 40));
        send_item(ACT_LOOKUP, '1);

        // one bit compared and indexed
        write_length(7'd1);
        send_item(ACT_LOOKUP_INSERT, 64'h8000_0000_0000_0003);
        send_item(ACT_LOOKUP, 64'h7);

        // random phases over a range of key lengths
        phase_len = '{64, 8, 5, 0, 127, 1, 33, 0};
        phase_len[7] = $urandom_range(1, 64);
        for (int p = 0; p < 8; p++) begin
            write_length(LEN_W'(phase_len[p]));
            calm = (p == 2);
            random_phase(45);
        end
        calm = 1'b0;

        drain();
        // let any stray result show up before the verdict
        repeat (20) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
